>>> design/dklt_pkg.sv
// Shared types and constants for the dual-key lookup table.
package dklt_pkg;

  // Default sizes of the table and its fields
  localparam int TABLE_DEPTH_DEF     = 16;
  localparam int PRIMARY_WIDTH_DEF   = 32;
  localparam int SECONDARY_WIDTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF     = 32;

  // Sideband widths
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int IN_USER_W  = CMD_W + 2;
  localparam int OUT_USER_W = STATUS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_LOOKUP_PRI = 2'd1,
    CMD_LOOKUP_SEC = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_KEY    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_t;

endpackage

>>> design/dual_key_lookup_table_unit.sv
// Dual-key lookup table: entry memory, sequential key scan and result register.
// Steps: IDLE takes the input transfer; SCAN reads one stored entry from the memory port
// per cycle and compares each as it returns; FINISH loads the result once the output
// register is free. A new item is taken only after the last result is handed over.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low) empties the table through its fill count; the entry
// memory itself is not cleared, and slots at or above the fill count are never read.
module dual_key_lookup_table_unit #(
  parameter int TABLE_DEPTH     = dklt_pkg::TABLE_DEPTH_DEF,
  parameter int PRIMARY_WIDTH   = dklt_pkg::PRIMARY_WIDTH_DEF,
  parameter int SECONDARY_WIDTH = dklt_pkg::SECONDARY_WIDTH_DEF,
  parameter int VALUE_WIDTH     = dklt_pkg::VALUE_WIDTH_DEF,
  localparam int IN_DATA_W  = ((PRIMARY_WIDTH + SECONDARY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // primary_key, secondary_key, entry_value (low bit up), zero padded
  input  logic [IN_DATA_W-1:0]            in_tdata,
  // command[1:0], primary_present, secondary_present
  input  logic [dklt_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found_value, zero padded
  output logic [OUT_DATA_W-1:0]           out_tdata,
  // status[2:0]
  output logic [dklt_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int E_PP    = 0;
  localparam int E_PK    = 1;
  localparam int E_SP    = 1 + PRIMARY_WIDTH;
  localparam int E_SK    = 2 + PRIMARY_WIDTH;
  localparam int E_VAL   = 2 + PRIMARY_WIDTH + SECONDARY_WIDTH;
  localparam int ENTRY_W = 2 + PRIMARY_WIDTH + SECONDARY_WIDTH + VALUE_WIDTH;

  // Control state
  dklt_pkg::fsm_t state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           rd_pend_r;
  logic           rd_en;
  logic           wr_en;
  logic           dup_r, dup_nxt;
  logic           hit_r, hit_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  logic           out_load;

  // Held item
  logic [dklt_pkg::CMD_W-1:0] cmd_r;
  logic                       pp_r;
  logic                       sp_r;
  logic [PRIMARY_WIDTH-1:0]   pk_r;
  logic [SECONDARY_WIDTH-1:0] sk_r;
  logic [VALUE_WIDTH-1:0]     val_r;

  // Scan data path
  logic [ENTRY_W-1:0]         mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]         rd_data_r;
  logic [ENTRY_W-1:0]         wr_entry;
  logic [VALUE_WIDTH-1:0]     found_r, found_nxt;
  logic                       e_pp;
  logic                       e_sp;
  logic [PRIMARY_WIDTH-1:0]   e_pk;
  logic [SECONDARY_WIDTH-1:0] e_sk;
  logic [VALUE_WIDTH-1:0]     e_val;
  logic                       pri_match;
  logic                       sec_match;

  // Result
  logic [dklt_pkg::STATUS_W-1:0] res_status;
  logic                          res_write;
  logic [dklt_pkg::STATUS_W-1:0] out_status_r;
  logic [VALUE_WIDTH-1:0]        out_found_r;

  // Split the entry read back from memory
  assign e_pp  = rd_data_r[E_PP];
  assign e_pk  = rd_data_r[E_PK +: PRIMARY_WIDTH];
  assign e_sp  = rd_data_r[E_SP];
  assign e_sk  = rd_data_r[E_SK +: SECONDARY_WIDTH];
  assign e_val = rd_data_r[E_VAL +: VALUE_WIDTH];

  assign pri_match = e_pp && (e_pk == pk_r);
  assign sec_match = e_sp && (e_sk == sk_r);

  // Absent keys are stored as zero with their flag clear
  assign wr_entry = {val_r,
                     (sp_r ? sk_r : {SECONDARY_WIDTH{1'b0}}), sp_r,
                     (pp_r ? pk_r : {PRIMARY_WIDTH{1'b0}}), pp_r};

  // Decide the result of the held item from the scan flags
  always_comb begin
    res_write  = 1'b0;
    res_status = dklt_pkg::ST_NOT_FOUND;
    case (cmd_r)
      dklt_pkg::CMD_INSERT: begin
        if (!pp_r && !sp_r) begin
          res_status = dklt_pkg::ST_NO_KEY;
        end else if (dup_r) begin
          res_status = dklt_pkg::ST_DUPLICATE;
        end else if (count_r == CW'(TABLE_DEPTH)) begin
          res_status = dklt_pkg::ST_FULL;
        end else begin
          res_status = dklt_pkg::ST_OK;
          res_write  = 1'b1;
        end
      end
      dklt_pkg::CMD_LOOKUP_PRI, dklt_pkg::CMD_LOOKUP_SEC: begin
        res_status = hit_r ? dklt_pkg::ST_OK : dklt_pkg::ST_NOT_FOUND;
      end
      default: begin
        res_status = dklt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Sequencer: next state, scan compare and result hand-off
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    dup_nxt        = dup_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    out_load       = 1'b0;
    in_tready      = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    // Compare the entry read in the previous cycle
    if (rd_pend_r) begin
      case (cmd_r)
        dklt_pkg::CMD_INSERT: begin
          if ((pp_r && pri_match) || (sp_r && sec_match)) begin
            dup_nxt = 1'b1;
          end
        end
        dklt_pkg::CMD_LOOKUP_PRI: begin
          if (pri_match) begin
            hit_nxt   = 1'b1;
            found_nxt = e_val;
          end
        end
        dklt_pkg::CMD_LOOKUP_SEC: begin
          if (sec_match) begin
            hit_nxt   = 1'b1;
            found_nxt = e_val;
          end
        end
        default: begin
          dup_nxt = dup_r;
        end
      endcase
    end

    case (state_r)
      dklt_pkg::FSM_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt   = '0;
          dup_nxt   = 1'b0;
          hit_nxt   = 1'b0;
          found_nxt = '0;
          state_nxt = dklt_pkg::FSM_SCAN;
        end
      end
      dklt_pkg::FSM_SCAN: begin
        // Issue one read per cycle over the filled slots
        if (idx_r < count_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else begin
          state_nxt = dklt_pkg::FSM_FINISH;
        end
      end
      dklt_pkg::FSM_FINISH: begin
        // Hand over once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          if (res_write) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = dklt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = dklt_pkg::FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dklt_pkg::FSM_IDLE;
      idx_r        <= '0;
      count_r      <= '0;
      rd_pend_r    <= 1'b0;
      dup_r        <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      count_r      <= count_nxt;
      rd_pend_r    <= rd_en;
      dup_r        <= dup_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Hold the accepted item and the result payload
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser[dklt_pkg::CMD_W-1:0];
      pp_r  <= in_tuser[dklt_pkg::CMD_W];
      sp_r  <= in_tuser[dklt_pkg::CMD_W+1];
      pk_r  <= in_tdata[PRIMARY_WIDTH-1:0];
      sk_r  <= in_tdata[PRIMARY_WIDTH +: SECONDARY_WIDTH];
      val_r <= in_tdata[PRIMARY_WIDTH+SECONDARY_WIDTH +: VALUE_WIDTH];
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_found_r  <= found_r;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'(out_found_r);

`ifndef NO_ASSERTIONS
  // The fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // The scan index never runs past the filled slots
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("scan index beyond fill count");

  // The fill count only grows, one slot at a time, on a result hand-off
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + CW'(1)) && $past(out_load)))
    else $error("fill count changed outside an insert");

  // A new result appears only from the finishing step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_tvalid_r && !$past(out_tvalid_r)) |->
      ($past(state_r) == dklt_pkg::FSM_FINISH))
    else $error("result raised outside the finishing step");
`endif

endmodule
